// ----- rtl/cbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    // Word kinds on the input channel
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    // Result targets
    localparam logic [1:0] TGT_NONE   = 2'd0;
    localparam logic [1:0] TGT_CHR    = 2'd1;
    localparam logic [1:0] TGT_PRG    = 2'd2;
    localparam logic [1:0] TGT_MIRROR = 2'd3;

    // Register decode
    localparam logic [15:0] ADDR_MASK      = 16'hF003;
    localparam logic [15:0] REG_BANK_SEL   = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA  = 16'h8001;
    localparam logic [15:0] REG_MIRROR     = 16'hA000;
    localparam logic [15:0] REG_IRQ_RELOAD = 16'hC000;
    localparam logic [15:0] REG_IRQ_MODE   = 16'hC001;
    localparam logic [15:0] REG_IRQ_OFF    = 16'hE000;
    localparam logic [15:0] REG_IRQ_ON     = 16'hE001;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_PAIR
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic take;   // input word accepted this cycle
        logic tick;   // finish a tick batch and load its result
        logic pair;   // load the second result of a CHR pair
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic is_pair;
    } t_dp_sts;

endpackage

// ----- rtl/cbm_in_if.sv -----
// Input channel: CPU writes, tick batches and scanline ends.
interface cbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [15:0] address;
    logic [7:0] data;
    logic [7:0] cycles;
    logic [8:0] scanline;
    logic       display_on;

    modport source (output valid, kind, address, data, cycles, scanline, display_on,
                    input ready);
    modport sink   (input valid, kind, address, data, cycles, scanline, display_on,
                    output ready);
endinterface

// ----- rtl/cbm_out_if.sv -----
// Output channel: bank change results.
interface cbm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] target;
    logic [2:0] slot;
    logic [8:0] bank;
    logic       irq_line;
    logic       last;

    modport source (output valid, target, slot, bank, irq_line, last, input ready);
    modport sink   (input valid, target, slot, bank, irq_line, last, output ready);
endinterface

// ----- rtl/cartridge_bank_mapper_with_irq.sv -----
// A write or scanline word gives its result in the cycle after acceptance.
// A tick batch: reciprocal product on acceptance, then correction and count-down.
// One word per cycle for single-result words while the output is free; tick
// batches and CHR pair writes hold off input while in ST_TICK or ST_PAIR.
// Synchronous active-low reset clears all mapper and IRQ state and the output valid.
module cartridge_bank_mapper_with_irq
    import cbm_pkg::*;
#(
    parameter int VISIBLE_LINES = 240,
    parameter int PRESCALE      = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbm_in_if.sink    i_in,
    cbm_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cbm_datapath #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .PRESCALE      (PRESCALE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_kind       (i_in.kind),
        .i_address    (i_in.address),
        .i_data       (i_in.data),
        .i_cycles     (i_in.cycles),
        .i_scanline   (i_in.scanline),
        .i_display_on (i_in.display_on),
        .o_sts        (sts),
        .o_target     (o_out.target),
        .o_slot       (o_out.slot),
        .o_bank       (o_out.bank),
        .o_irq_line   (o_out.irq_line),
        .o_last       (o_out.last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // No new word while a tick batch is being resolved
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.kind == KIND_TICK) |=> !i_in.ready)
        else $error("word accepted during tick resolution");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take, cmd.tick, cmd.pair}))
        else $error("conflicting datapath commands");

    // Only the first word of a CHR pair is not last
    a_pair_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last |-> o_out.target == TGT_CHR)
        else $error("non-last word outside a CHR pair");

    // Second pair word closes the sequence
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pair |=> o_out.valid && o_out.last)
        else $error("second pair word not marked last");

endmodule

// ----- rtl/cbm_ctrl.sv -----
// Controller state machine: handshakes and sequencing of the datapath.
module cbm_ctrl
    import cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   load;

    // Output register can take a word this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && out_free) begin
                    if (i_sts.is_tick) begin
                        n_state = ST_TICK;
                    end else if (i_sts.is_pair) begin
                        n_state = ST_PAIR;
                    end
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAIR: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                o_cmd.take = i_in_valid && out_free;
            end
            ST_TICK: o_cmd.tick = out_free;
            ST_PAIR: o_cmd.pair = out_free;
            default: o_cmd = '0;
        endcase
    end

    assign load = (o_cmd.take && !i_sts.is_tick) || o_cmd.tick || o_cmd.pair;

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/cbm_datapath.sv -----
// Datapath: mapper registers, IRQ counter, tick divider and result register.
module cbm_datapath
    import cbm_pkg::*;
#(
    parameter int VISIBLE_LINES = 240,
    parameter int PRESCALE      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_cycles,
    input  logic [8:0]  i_scanline,
    input  logic        i_display_on,
    output t_dp_sts     o_sts,
    output logic [1:0]  o_target,
    output logic [2:0]  o_slot,
    output logic [8:0]  o_bank,
    output logic        o_irq_line,
    output logic        o_last
);

    localparam int TotMax   = 255 + PRESCALE - 1;
    localparam int TotW     = $clog2(TotMax + 1);
    localparam int PsW      = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
    localparam int DivShift = 18;
    localparam int DivMul   = ((1 << DivShift) + PRESCALE - 1) / PRESCALE;
    localparam int ProdW    = DivShift + TotW + 1;
    localparam int RemW     = TotW + 1;
    localparam logic [9:0] COUNT_STOP = 10'h3FF;

    // Mapper and IRQ state
    logic [3:0]     r_bank_index, n_bank_index;
    logic           r_prg_invert, n_prg_invert;
    logic           r_chr_invert, n_chr_invert;
    logic           r_irq_enabled, n_irq_enabled;
    logic           r_cycle_mode, n_cycle_mode;
    logic [9:0]     r_irq_count, n_irq_count;
    logic [PsW-1:0] r_prescale, n_prescale;
    logic [7:0]     r_reload_value, n_reload_value;
    logic           r_reload_pending, n_reload_pending;
    logic           r_irq_out, n_irq_out;

    // Tick batch and pair holding registers
    logic [TotW-1:0]  r_total;
    logic [ProdW-1:0] r_prod;
    logic [2:0]       r_pair_slot;
    logic [7:0]       r_pair_data;

    // Output word
    logic [1:0] r_target, n_target;
    logic [2:0] r_slot, n_slot;
    logic [8:0] r_bank, n_bank;
    logic       r_irq_line;
    logic       r_last, n_last;

    logic [15:0]     masked;
    logic [1:0]      wr_tgt;
    logic            wr_pair;
    logic [2:0]      wr_slot;
    logic [TotW-1:0] total;
    logic [TotW-1:0] q_est;
    logic [RemW-1:0] qp;
    logic [RemW-1:0] rem;
    logic            fix;
    logic [TotW-1:0] q;
    logic [RemW-1:0] rem_fix;
    logic [10:0]     dec_amt;
    logic [10:0]     diff;
    logic            can_dec;
    logic            underflow;
    logic            is_write;
    logic            line_hit;

    assign masked   = i_address & ADDR_MASK;
    assign is_write = (i_kind == KIND_WRITE);

    // Bank data write: target and slot from the selected index
    always_comb begin
        wr_tgt  = TGT_NONE;
        wr_pair = 1'b0;
        wr_slot = 3'd0;
        unique case (r_bank_index)
            4'd0: begin
                wr_tgt = TGT_CHR; wr_pair = 1'b1; wr_slot = r_chr_invert ? 3'd4 : 3'd0;
            end
            4'd1: begin
                wr_tgt = TGT_CHR; wr_pair = 1'b1; wr_slot = r_chr_invert ? 3'd6 : 3'd2;
            end
            4'd2: begin wr_tgt = TGT_CHR; wr_slot = r_chr_invert ? 3'd0 : 3'd4; end
            4'd3: begin wr_tgt = TGT_CHR; wr_slot = r_chr_invert ? 3'd1 : 3'd5; end
            4'd4: begin wr_tgt = TGT_CHR; wr_slot = r_chr_invert ? 3'd2 : 3'd6; end
            4'd5: begin wr_tgt = TGT_CHR; wr_slot = r_chr_invert ? 3'd3 : 3'd7; end
            4'd6: begin wr_tgt = TGT_PRG; wr_slot = r_prg_invert ? 3'd5 : 3'd4; end
            4'd7: begin wr_tgt = TGT_PRG; wr_slot = r_prg_invert ? 3'd6 : 3'd5; end
            4'd8: begin wr_tgt = TGT_CHR; wr_slot = 3'd1; end
            4'd9: begin wr_tgt = TGT_CHR; wr_slot = 3'd3; end
            4'd15: begin wr_tgt = TGT_PRG; wr_slot = r_prg_invert ? 3'd4 : 3'd6; end
            default: begin wr_tgt = TGT_NONE; end
        endcase
    end

    assign o_sts.is_tick = (i_kind == KIND_TICK);
    assign o_sts.is_pair = is_write && (masked == REG_BANK_DATA) && wr_pair;

    // Tick batch: cycle total and its reciprocal product
    assign total = TotW'(r_prescale) + TotW'(i_cycles);

    // Quotient by the prescaler, with one compare-subtract correction
    assign q_est   = r_prod[DivShift +: TotW];
    assign qp      = RemW'(q_est) * RemW'(PRESCALE);
    assign rem     = RemW'(r_total) - qp;
    assign fix     = (rem >= RemW'(PRESCALE));
    assign q       = fix ? q_est + TotW'(1) : q_est;
    assign rem_fix = fix ? rem - RemW'(PRESCALE) : rem;

    // Shared counter decrement
    assign line_hit  = (i_scanline < 9'(VISIBLE_LINES)) && i_display_on;
    assign dec_amt   = i_cmd.tick ? 11'(q) : 11'd1;
    assign can_dec   = !r_irq_count[9] && (dec_amt != 11'd0);
    assign diff      = {2'b00, r_irq_count[8:0]} - dec_amt;
    assign underflow = diff[10];

    // State update and result word
    always_comb begin
        n_bank_index     = r_bank_index;
        n_prg_invert     = r_prg_invert;
        n_chr_invert     = r_chr_invert;
        n_irq_enabled    = r_irq_enabled;
        n_cycle_mode     = r_cycle_mode;
        n_irq_count      = r_irq_count;
        n_prescale       = r_prescale;
        n_reload_value   = r_reload_value;
        n_reload_pending = r_reload_pending;
        n_irq_out        = r_irq_out;
        n_target         = TGT_NONE;
        n_slot           = 3'd0;
        n_bank           = 9'd0;
        n_last           = 1'b1;

        if (i_cmd.tick) begin
            if (r_cycle_mode) begin
                n_prescale = rem_fix[PsW-1:0];
                if (can_dec) begin
                    if (underflow) begin
                        n_irq_count = COUNT_STOP;
                        n_irq_out   = r_irq_out | r_irq_enabled;
                    end else begin
                        n_irq_count = diff[9:0];
                    end
                end
            end
        end else if (i_cmd.pair) begin
            n_target = TGT_CHR;
            n_slot   = r_pair_slot + 3'd1;
            n_bank   = {1'b0, r_pair_data} + 9'd1;
        end else if (i_cmd.take && is_write) begin
            unique case (masked)
                REG_BANK_SEL: begin
                    n_bank_index = i_data[3:0];
                    n_prg_invert = i_data[6];
                    n_chr_invert = i_data[7];
                end
                REG_BANK_DATA: begin
                    n_target = wr_tgt;
                    if (wr_tgt != TGT_NONE) begin
                        n_slot = wr_slot;
                        n_bank = {1'b0, i_data};
                        n_last = !wr_pair;
                    end
                end
                REG_MIRROR: begin
                    n_target = TGT_MIRROR;
                    n_bank   = {8'd0, i_data[0]};
                end
                REG_IRQ_RELOAD: begin
                    n_reload_value = i_data;
                    if (r_reload_pending) begin
                        n_irq_count = {2'b00, i_data};
                    end
                end
                REG_IRQ_MODE: begin
                    n_reload_pending = 1'b1;
                    n_irq_count      = {2'b00, r_reload_value};
                    n_cycle_mode     = i_data[0];
                end
                REG_IRQ_OFF: begin
                    n_irq_enabled = 1'b0;
                    n_irq_out     = 1'b0;
                    if (r_reload_pending) begin
                        n_irq_count = {2'b00, r_reload_value};
                    end
                end
                REG_IRQ_ON: begin
                    n_irq_enabled = 1'b1;
                    if (r_reload_pending) begin
                        n_irq_count = {2'b00, r_reload_value};
                    end
                end
                default: begin
                    n_target = TGT_NONE;
                end
            endcase
        end else if (i_cmd.take && (i_kind == KIND_LINE) && !r_cycle_mode) begin
            n_reload_pending = 1'b0;
            if (line_hit && can_dec) begin
                if (underflow) begin
                    n_irq_count = COUNT_STOP;
                    n_irq_out   = r_irq_out | r_irq_enabled;
                    n_reload_pending = r_irq_enabled;
                end else begin
                    n_irq_count = diff[9:0];
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_index     <= '0;
            r_prg_invert     <= 1'b0;
            r_chr_invert     <= 1'b0;
            r_irq_enabled    <= 1'b0;
            r_cycle_mode     <= 1'b0;
            r_irq_count      <= '0;
            r_prescale       <= '0;
            r_reload_value   <= '0;
            r_reload_pending <= 1'b0;
            r_irq_out        <= 1'b0;
        end else begin
            r_bank_index     <= n_bank_index;
            r_prg_invert     <= n_prg_invert;
            r_chr_invert     <= n_chr_invert;
            r_irq_enabled    <= n_irq_enabled;
            r_cycle_mode     <= n_cycle_mode;
            r_irq_count      <= n_irq_count;
            r_prescale       <= n_prescale;
            r_reload_value   <= n_reload_value;
            r_reload_pending <= n_reload_pending;
            r_irq_out        <= n_irq_out;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_total     <= total;
            r_prod      <= ProdW'(total) * ProdW'(DivMul);
            r_pair_slot <= wr_slot;
            r_pair_data <= i_data;
        end
        if ((i_cmd.take && !o_sts.is_tick) || i_cmd.tick || i_cmd.pair) begin
            r_target   <= n_target;
            r_slot     <= n_slot;
            r_bank     <= n_bank;
            r_irq_line <= n_irq_out;
            r_last     <= n_last;
        end
    end

    assign o_target   = r_target;
    assign o_slot     = r_slot;
    assign o_bank     = r_bank;
    assign o_irq_line = r_irq_line;
    assign o_last     = r_last;

endmodule

// ----- bench/cartridge_bank_mapper_with_irq_tb.sv -----
// Self-checking testbench for the cartridge bank mapper with IRQ counter.
module cartridge_bank_mapper_with_irq_tb;
    import cbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VISIBLE_LINES = 240;
    localparam int PRESCALE      = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 40;

    // Kind code that the block does not know
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Bank select, mirroring and IRQ mode word bits
    localparam logic [7:0] INV_PRG    = 8'h40;
    localparam logic [7:0] INV_CHR    = 8'h80;
    localparam logic [7:0] MIRROR_BIT = 8'h01;
    localparam logic [7:0] MODE_CYCLE = 8'h01;

    // Bank register selected by the low nibble of a bank select word
    typedef enum logic [3:0] {
        SEL_CHR_PAIR_A = 4'd0,
        SEL_CHR_PAIR_B = 4'd1,
        SEL_CHR_C      = 4'd2,
        SEL_CHR_D      = 4'd3,
        SEL_CHR_E      = 4'd4,
        SEL_CHR_F      = 4'd5,
        SEL_PRG_A      = 4'd6,
        SEL_PRG_B      = 4'd7,
        SEL_CHR_G      = 4'd8,
        SEL_CHR_H      = 4'd9,
        SEL_SPARE_A    = 4'd10,
        SEL_SPARE_E    = 4'd14,
        SEL_PRG_C      = 4'd15
    } t_bank_sel;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  cycles;
        logic [8:0]  scanline;
        logic        display_on;
    } t_cpu_word;

    typedef struct {
        logic [1:0] target;
        logic [2:0] slot;
        logic [8:0] bank;
        logic       irq_line;
        logic       last;
    } t_mapping;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbm_in_if  in_if ();
    cbm_out_if out_if ();

    cartridge_bank_mapper_with_irq #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .PRESCALE      (PRESCALE)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted mapper state
    logic [3:0]        bank_sel;
    logic              prg_inv;
    logic              chr_inv;
    logic              irq_en;
    logic              cycle_mode;
    logic signed [9:0] irq_cnt;
    int                prescale_acc;
    logic [7:0]        reload_byte;
    logic              reload_armed;
    logic              irq_out;

    t_mapping mapping_q[$];
    int       mismatch_count = 0;
    int       words_sent     = 0;
    int       cycle_count    = 0;
    bit       src_calm       = 1'b0;
    bit       sink_calm      = 1'b0;

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_mapping(input logic [1:0] tgt, input logic [2:0] slot,
                                         input logic [8:0] bank, input logic last);
        t_mapping m;
        m.target   = tgt;
        m.slot     = slot;
        m.bank     = bank;
        m.irq_line = irq_out;
        m.last     = last;
        mapping_q.push_back(m);
    endfunction

    function automatic void reset_mapper_state();
        bank_sel     = '0;
        prg_inv      = 1'b0;
        chr_inv      = 1'b0;
        irq_en       = 1'b0;
        cycle_mode   = 1'b0;
        irq_cnt      = '0;
        prescale_acc = 0;
        reload_byte  = '0;
        reload_armed = 1'b0;
        irq_out      = 1'b0;
    endfunction

    // One count-down step; high when the counter has just reached -1
    function automatic bit count_irq_down();
        if (irq_cnt >= 0) begin
            irq_cnt = irq_cnt - 10'sd1;
            if (irq_cnt < 0) begin
                if (irq_en)
                    irq_out = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the results of one accepted word and updates the state
    function automatic void predict_mapper(input t_cpu_word w);
        logic [1:0] tgt;
        logic [2:0] slot_a;
        logic       pair;
        tgt    = TGT_NONE;
        slot_a = '0;
        pair   = 1'b0;
        case (w.kind)
            KIND_WRITE: begin
                case (w.address & ADDR_MASK)
                    REG_BANK_SEL: begin
                        bank_sel = w.data[3:0];
                        prg_inv  = |(w.data & INV_PRG);
                        chr_inv  = |(w.data & INV_CHR);
                    end
                    REG_BANK_DATA: begin
                        case (bank_sel)
                            SEL_CHR_PAIR_A: begin
                                tgt = TGT_CHR; pair = 1'b1; slot_a = chr_inv ? 3'd4 : 3'd0;
                            end
                            SEL_CHR_PAIR_B: begin
                                tgt = TGT_CHR; pair = 1'b1; slot_a = chr_inv ? 3'd6 : 3'd2;
                            end
                            SEL_CHR_C: begin tgt = TGT_CHR; slot_a = chr_inv ? 3'd0 : 3'd4; end
                            SEL_CHR_D: begin tgt = TGT_CHR; slot_a = chr_inv ? 3'd1 : 3'd5; end
                            SEL_CHR_E: begin tgt = TGT_CHR; slot_a = chr_inv ? 3'd2 : 3'd6; end
                            SEL_CHR_F: begin tgt = TGT_CHR; slot_a = chr_inv ? 3'd3 : 3'd7; end
                            SEL_PRG_A: begin tgt = TGT_PRG; slot_a = prg_inv ? 3'd5 : 3'd4; end
                            SEL_PRG_B: begin tgt = TGT_PRG; slot_a = prg_inv ? 3'd6 : 3'd5; end
                            SEL_CHR_G: begin tgt = TGT_CHR; slot_a = 3'd1; end
                            SEL_CHR_H: begin tgt = TGT_CHR; slot_a = 3'd3; end
                            SEL_PRG_C: begin tgt = TGT_PRG; slot_a = prg_inv ? 3'd4 : 3'd6; end
                            default: ;
                        endcase
                    end
                    REG_MIRROR: tgt = TGT_MIRROR;
                    REG_IRQ_RELOAD: begin
                        reload_byte = w.data;
                        if (reload_armed)
                            irq_cnt = {2'b00, reload_byte};
                    end
                    REG_IRQ_MODE: begin
                        reload_armed = 1'b1;
                        irq_cnt      = {2'b00, reload_byte};
                        cycle_mode   = |(w.data & MODE_CYCLE);
                    end
                    REG_IRQ_OFF: begin
                        irq_en = 1'b0;
                        if (reload_armed)
                            irq_cnt = {2'b00, reload_byte};
                        irq_out = 1'b0;
                    end
                    REG_IRQ_ON: begin
                        irq_en = 1'b1;
                        if (reload_armed)
                            irq_cnt = {2'b00, reload_byte};
                    end
                    default: ;
                endcase
            end
            KIND_TICK: begin
                // Tick batches are prescaled and count only in cycle mode
                if (cycle_mode) begin
                    prescale_acc += w.cycles;
                    while (prescale_acc >= PRESCALE) begin
                        prescale_acc -= PRESCALE;
                        void'(count_irq_down());
                    end
                end
            end
            KIND_LINE: begin
                // Visible lines with rendering on count only in scanline mode
                if (!cycle_mode) begin
                    reload_armed = 1'b0;
                    if (w.scanline < VISIBLE_LINES && w.display_on) begin
                        if (count_irq_down() && irq_en)
                            reload_armed = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (tgt == TGT_NONE)
            push_mapping(TGT_NONE, 3'd0, 9'd0, 1'b1);
        else if (tgt == TGT_MIRROR)
            push_mapping(TGT_MIRROR, 3'd0, {1'b0, w.data & MIRROR_BIT}, 1'b1);
        else if (pair) begin
            push_mapping(tgt, slot_a, {1'b0, w.data}, 1'b0);
            push_mapping(tgt, slot_a + 3'd1, {1'b0, w.data} + 9'd1, 1'b1);
        end else
            push_mapping(tgt, slot_a, {1'b0, w.data}, 1'b1);
    endfunction

    // Word builders: fields the block ignores are random
    function automatic t_cpu_word random_word();
        t_cpu_word w;
        w.kind       = 2'($urandom_range(0, 3));
        w.address    = 16'($urandom);
        w.data       = 8'($urandom);
        w.cycles     = 8'($urandom);
        w.scanline   = 9'($urandom);
        w.display_on = 1'($urandom);
        return w;
    endfunction

    function automatic t_cpu_word reg_write(input logic [15:0] reg_addr,
                                            input logic [7:0] value);
        t_cpu_word w;
        w         = random_word();
        w.kind    = KIND_WRITE;
        w.address = reg_addr | (16'($urandom) & ~ADDR_MASK);
        w.data    = value;
        return w;
    endfunction

    function automatic t_cpu_word line_end(input logic [8:0] line, input logic disp);
        t_cpu_word w;
        w            = random_word();
        w.kind       = KIND_LINE;
        w.scanline   = line;
        w.display_on = disp;
        return w;
    endfunction

    function automatic t_cpu_word tick_batch(input logic [7:0] cycles);
        t_cpu_word w;
        w        = random_word();
        w.kind   = KIND_TICK;
        w.cycles = cycles;
        return w;
    endfunction

    // Sends one word; valid stays high into the next word when there is no gap
    task automatic send_word(input t_cpu_word w);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.kind       <= w.kind;
        in_if.address    <= w.address;
        in_if.data       <= w.data;
        in_if.cycles     <= w.cycles;
        in_if.scanline   <= w.scanline;
        in_if.display_on <= w.display_on;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        predict_mapper(w);
        words_sent++;
    endtask

    // Source goes idle until every expected result has been taken
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (mapping_q.size() != 0);
    endtask

    // Result side: random back-pressure and field-by-field comparison
    initial begin : result_sink
        int       stall_left;
        t_mapping want;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (mapping_q.size() == 0)
                    report_mismatch("result with nothing pending", out_if.target, -1);
                else begin
                    want = mapping_q.pop_front();
                    if (out_if.target !== want.target)
                        report_mismatch("target", out_if.target, want.target);
                    if (out_if.slot !== want.slot)
                        report_mismatch("slot", out_if.slot, want.slot);
                    if (out_if.bank !== want.bank)
                        report_mismatch("bank", out_if.bank, want.bank);
                    if (out_if.irq_line !== want.irq_line)
                        report_mismatch("irq_line", out_if.irq_line, want.irq_line);
                    if (out_if.last !== want.last)
                        report_mismatch("last", out_if.last, want.last);
                end
            end
            if (!i_rst_n)
                out_if.ready <= 1'b0;
            else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = pick_gap(sink_calm);
            end
        end
    end

    // Bank select, CHR/PRG slot mapping, mirroring, undecoded writes and an unknown kind
    task automatic test_bank_mapping();
        t_cpu_word w;
        send_word(reg_write(REG_BANK_SEL, 8'(SEL_CHR_PAIR_A)));
        send_word(reg_write(REG_BANK_DATA, 8'hFF));
        send_word(reg_write(REG_BANK_SEL, INV_CHR | 8'(SEL_CHR_PAIR_B)));
        send_word(reg_write(REG_BANK_DATA, 8'h00));
        send_word(reg_write(REG_BANK_SEL, INV_PRG | 8'(SEL_PRG_A)));
        send_word(reg_write(REG_BANK_DATA, 8'h12));
        send_word(reg_write(REG_BANK_SEL, INV_PRG | INV_CHR | 8'(SEL_PRG_C)));
        send_word(reg_write(REG_BANK_DATA, 8'hFF));
        // Unused bank index: no mapping change
        send_word(reg_write(REG_BANK_SEL, 8'(SEL_SPARE_A)));
        send_word(reg_write(REG_BANK_DATA, 8'h55));
        send_word(reg_write(REG_MIRROR, 8'h01));
        send_word(reg_write(REG_MIRROR, 8'hFE));
        // Below the register window, and all address bits set
        w = reg_write(REG_BANK_DATA, 8'h33);
        w.address = 16'h7FFF;
        send_word(w);
        w.address = 16'hFFFF;
        send_word(w);
        // Unknown kind
        w = random_word();
        w.kind = KIND_UNKNOWN;
        send_word(w);
    endtask

    // Scanline counting, underflow, reload and acknowledge
    task automatic test_scanline_irq();
        send_word(reg_write(REG_IRQ_RELOAD, 8'd2));
        send_word(reg_write(REG_IRQ_MODE, 8'h00));
        send_word(reg_write(REG_IRQ_ON, 8'h00));
        send_word(line_end(9'd0, 1'b1));
        send_word(line_end(9'd239, 1'b1));
        send_word(line_end(9'd10, 1'b1));
        // Counter held at -1, then an invisible line and rendering off
        send_word(line_end(9'd11, 1'b1));
        send_word(line_end(9'd511, 1'b1));
        send_word(line_end(9'd12, 1'b0));
        send_word(reg_write(REG_IRQ_OFF, 8'h00));
    endtask

    // Cycle mode with prescaling; scanline ends are ignored there
    task automatic test_cycle_irq();
        send_word(reg_write(REG_IRQ_RELOAD, 8'd255));
        send_word(reg_write(REG_IRQ_MODE, MODE_CYCLE));
        send_word(reg_write(REG_IRQ_ON, 8'h00));
        send_word(tick_batch(8'd0));
        send_word(tick_batch(8'd255));
        send_word(line_end(9'd5, 1'b1));
        send_word(reg_write(REG_IRQ_RELOAD, 8'd0));
        send_word(tick_batch(8'd3));
        send_word(tick_batch(8'd255));
        send_word(reg_write(REG_IRQ_OFF, 8'h00));
    endtask

    // Mostly well-formed select/data pairs, with mirroring writes and noise
    task automatic test_random_banking(input int count);
        int stop_at;
        int r;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            src_calm  = ($urandom_range(0, 5) == 0);
            sink_calm = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_word(reg_write(REG_BANK_SEL, 8'($urandom)));
                send_word(reg_write(REG_BANK_DATA, 8'($urandom)));
            end else if (r < 80)
                send_word(reg_write(REG_MIRROR, 8'($urandom)));
            else
                send_word(random_word());
        end
    endtask

    // IRQ set-up followed by runs of counting events, with noise between
    task automatic test_random_irq(input int count, input logic use_cycles);
        int   stop_at;
        int   run_len;
        logic [7:0] latch;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            src_calm  = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                latch = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
                send_word(reg_write(REG_IRQ_RELOAD, latch));
                send_word(reg_write(REG_IRQ_MODE,
                                    (8'($urandom) & ~MODE_CYCLE) | 8'(use_cycles)));
                send_word(reg_write(($urandom_range(0, 4) == 0) ? REG_IRQ_OFF : REG_IRQ_ON,
                                    8'($urandom)));
                run_len = $urandom_range(3, 20);
                repeat (run_len) begin
                    case ($urandom_range(0, 19))
                        0: send_word(reg_write(REG_IRQ_OFF, 8'($urandom)));
                        1: send_word(reg_write(REG_IRQ_ON, 8'($urandom)));
                        2: send_word(reg_write(REG_IRQ_RELOAD, 8'($urandom_range(0, 12))));
                        3: send_word(random_word());
                        4: send_word(use_cycles ? line_end(9'($urandom), 1'($urandom))
                                                : tick_batch(8'($urandom)));
                        default: begin
                            if (use_cycles)
                                send_word(tick_batch(($urandom_range(0, 9) == 0)
                                                     ? 8'($urandom)
                                                     : 8'($urandom_range(0, 12))));
                            else if ($urandom_range(0, 9) == 0)
                                send_word(line_end(9'($urandom), 1'($urandom)));
                            else
                                send_word(line_end(9'($urandom_range(0, VISIBLE_LINES - 1)),
                                                   1'b1));
                        end
                    endcase
                end
            end else
                send_word(random_word());
            // Let the output side catch up now and then
            if ($urandom_range(0, 15) == 0)
                wait_for_drain();
        end
    endtask

    initial begin
        reset_mapper_state();
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.kind       <= KIND_WRITE;
        in_if.address    <= '0;
        in_if.data       <= '0;
        in_if.cycles     <= '0;
        in_if.scanline   <= '0;
        in_if.display_on <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bank_mapping();
        test_scanline_irq();
        test_cycle_irq();
        wait_for_drain();
        test_random_banking(140);
        wait_for_drain();
        test_random_irq(140, 1'b0);
        wait_for_drain();
        test_random_irq(140, 1'b1);

        // Drain and let any stray result show up
        wait_for_drain();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- cartridge_bank_mapper_with_irq.f -----
rtl/cbm_pkg.sv
rtl/cbm_in_if.sv
rtl/cbm_out_if.sv
rtl/cbm_ctrl.sv
rtl/cbm_datapath.sv
rtl/cartridge_bank_mapper_with_irq.sv
bench/cartridge_bank_mapper_with_irq_tb.sv
